// ===== sv/oets_pkg.sv =====
package oets_pkg;

    // Defaults for the top-level parameters.
    localparam int C_MAX_ITEMS  = 32;
    localparam int C_DATA_WIDTH = 32;

    // Command fields are sized for the largest supported store (64 entries).
    localparam int C_IDX_W = 6;
    localparam int C_CNT_W = 7;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } t_item;

    typedef struct packed {
        logic signed [31:0] value_res;
        logic               last_res;
        logic               overflow;
    } t_res;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SORT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic               load;
        logic [C_IDX_W-1:0] idx;
        logic               phase;
        logic               parity;
        logic [C_CNT_W-1:0] count;
        logic               emit;
        logic               last;
        logic               overflow;
    } t_dp_cmd;

endpackage

// ===== sv/odd_even_transposition_sorter_top.sv =====
// Odd-even transposition sorter.
// Input: a beat is taken at each rising edge with start high and busy low; it
// carries one signed value and a last flag. Beats without last are stored one
// per cycle. Once MAX_ITEMS values are held, further values are dropped and
// every result of that set carries overflow.
// The beat with last closes the set of n values (the last value counts if it
// fit) and raises busy. The set is then sorted by compare-exchange phases,
// one per cycle, even and odd in turn, over the neighbor pairs in the set.
// Output: results come out in ascending order, one beat per cycle, marked by
// o_strobe for exactly one cycle each; last_res marks the final one. Each
// result is registered from cell 0 as the row shifts. The receiver cannot
// stall the block, so results must be taken as they appear.
// busy falls in the cycle of the final result, so the first beat of the next set
// can be taken in that cycle; the time between sets is made up of the loads,
// the sort phases and the one-per-cycle emit shift.
// Reset (synchronous, active low) empties the set, clears the overflow flag
// and drops any set in flight; stored values are not cleared.
module odd_even_transposition_sorter_top #(
    parameter int MAX_ITEMS  = oets_pkg::C_MAX_ITEMS,
    parameter int DATA_WIDTH = oets_pkg::C_DATA_WIDTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  oets_pkg::t_item i_item,
    output logic            busy,
    output logic            o_strobe,
    output oets_pkg::t_res  o_res
);
    import oets_pkg::*;

    t_dp_cmd w_cmd;

    oets_ctrl #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_last  (i_item.last),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    oets_dp #(
        .MAX_ITEMS  (MAX_ITEMS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_value  (i_item.value),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

endmodule

// ===== sv/oets_ctrl.sv =====
module oets_ctrl #(
    parameter int MAX_ITEMS = oets_pkg::C_MAX_ITEMS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             i_last,
    output logic             busy,
    output oets_pkg::t_dp_cmd o_cmd
);
    import oets_pkg::*;

    localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_cnt,   n_cnt;
    logic            r_drop,  n_drop;
    logic            w_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cnt   <= n_cnt;
            r_drop  <= n_drop;
        end
    end

    assign w_final = (r_cnt == r_count - CW'(1));
    assign busy    = (r_state != S_LOAD);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_cnt   = r_cnt;
        n_drop  = r_drop;
        o_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                if (start) begin
                    if (r_count < CW'(MAX_ITEMS)) begin
                        o_cmd.load = 1'b1;
                        o_cmd.idx  = C_IDX_W'(r_count[IW-1:0]);
                        n_count    = r_count + CW'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_last) begin
                        n_state = S_SORT;
                        n_cnt   = '0;
                    end
                end
            end
            S_SORT: begin
                o_cmd.phase  = 1'b1;
                o_cmd.parity = r_cnt[0];
                o_cmd.count  = C_CNT_W'(r_count);
                if (w_final) begin
                    n_cnt   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_EMIT: begin
                o_cmd.emit     = 1'b1;
                o_cmd.last     = w_final;
                o_cmd.overflow = r_drop;
                if (w_final) begin
                    n_state = S_LOAD;
                    n_count = '0;
                    n_cnt   = '0;
                    n_drop  = 1'b0;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // A beat that closes the set always hands the block over to sorting.
    a_last_starts_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last) |=> (busy && r_state == S_SORT && r_cnt == '0))
        else $error("last beat did not start the sort");

    a_phase_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> (r_cnt == '0))
        else $error("phase counter not zero between sets");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ITEMS))
        else $error("item count exceeds store depth");

    a_nonempty_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SORT || r_state == S_EMIT) |-> (r_count != '0 && r_cnt < r_count))
        else $error("sort or emit running on an empty set");

endmodule

// ===== sv/oets_dp.sv =====
module oets_dp #(
    parameter int MAX_ITEMS  = oets_pkg::C_MAX_ITEMS,
    parameter int DATA_WIDTH = oets_pkg::C_DATA_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  oets_pkg::t_dp_cmd i_cmd,
    input  logic signed [31:0] i_value,
    output logic              o_strobe,
    output oets_pkg::t_res    o_res
);
    import oets_pkg::*;

    localparam int EW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

    logic signed [DATA_WIDTH-1:0] r_store [MAX_ITEMS];
    logic signed [DATA_WIDTH-1:0] n_store [MAX_ITEMS];
    logic signed [EW-1:0]         w_in_low;
    logic signed [EW-1:0]         w_head_low;
    logic signed [DATA_WIDTH-1:0] w_in_ext;
    logic                         r_strobe;
    t_res                         r_res;

    assign w_in_low   = i_value[EW-1:0];
    assign w_in_ext   = DATA_WIDTH'(w_in_low);
    assign w_head_low = r_store[0][EW-1:0];

    // Each cell is written at load, takes part in at most one pair per phase,
    // and the whole row shifts toward cell 0 while the set is emitted.
    always_comb begin
        n_store = r_store;
        if (i_cmd.load) begin
            for (int k = 0; k < MAX_ITEMS; k++) begin
                if (i_cmd.idx == C_IDX_W'(k)) begin
                    n_store[k] = w_in_ext;
                end
            end
        end
        if (i_cmd.phase) begin
            for (int i = 0; i < MAX_ITEMS - 1; i++) begin
                if ((1'(i) == i_cmd.parity) && (C_CNT_W'(i + 1) < i_cmd.count)
                        && (r_store[i] > r_store[i+1])) begin
                    n_store[i]   = r_store[i+1];
                    n_store[i+1] = r_store[i];
                end
            end
        end
        if (i_cmd.emit) begin
            for (int k = 0; k < MAX_ITEMS - 1; k++) begin
                n_store[k] = r_store[k+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_store <= n_store;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_res.value_res <= 32'(w_head_low);
            r_res.last_res  <= i_cmd.last;
            r_res.overflow  <= i_cmd.overflow;
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule
